>>> rtl/core/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Types and codes shared by the bounded queue with membership search.
// ----------------------------------------------------------------------------
package bfs_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 4;
   localparam int COUNT_W  = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 4'd7;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_FIND = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DEQ  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

endpackage

>>> rtl/core/bounded_fifo_with_search_unit.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_search_unit
// Ring-buffer queue of signed 32-bit values with a programmable capacity,
// one request per start beat: enqueue, dequeue or membership find.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result beat
// appears on the rsp_ ports, flagged by rsp_valid for a single cycle, and the
// receiver cannot stall it. Enqueue, every request on an empty queue and the
// unused mode answer in the next cycle with busy staying low. Dequeue passes
// through ST_DEQ with busy high (one registered read of the slot memory). Find
// walks the held entries through the same single read port, one entry per
// cycle, and stops at the first match or after the last held entry. The
// capacity register may be written only while the block is idle; capacities
// above DEPTH act as DEPTH and zero refuses every enqueue.
module bounded_fifo_with_search_unit #(
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bfs_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [bfs_pkg::DATA_W-1:0]   req_value_in,
   output logic                                rsp_valid,
   output logic [bfs_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [bfs_pkg::DATA_W-1:0]   rsp_value_out,
   output logic                                rsp_found,
   output logic [bfs_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   input  logic                                csr_write_enable,
   input  logic [bfs_pkg::CAP_W-1:0]           csr_write_data
);
   import bfs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic              mem_we;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [OCC_W-1:0]  scan_left_ff, scan_left_in;
   logic [DATA_W-1:0] value_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [CMP_W-1:0]    occ_next_ext;

   logic accept;
   logic scan_match;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   // full when occupancy reaches min(capacity, DEPTH)
   function automatic logic is_full_f(input logic [OCC_W-1:0] occ,
                                      input logic [CAP_W-1:0] cap);
      logic f;
      f = (occ >= OCC_W'(DEPTH)) || (CMP_W'(occ) >= CMP_W'(cap));
      return f;
   endfunction

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign scan_match = (rd_data_ff == value_ff);

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      occ_in        = occ_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_left_in  = scan_left_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_value_in  = '0;
      rsp_found_in  = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = rd_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_mode))
                  MODE_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (is_full_f(occ_ff, cap_ff)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        wr_ptr_in = ptr_next(wr_ptr_ff);
                        occ_in    = occ_ff + 1'b1;
                     end
                  end
                  MODE_DEQ: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_value_in  = '1;
                     end else begin
                        state_in = ST_DEQ;
                     end
                  end
                  MODE_FIND: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in     = ST_SCAN;
                        scan_ptr_in  = ptr_next(rd_ptr_ff);
                        scan_left_in = occ_ff;
                     end
                  end
                  MODE_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DEQ: begin
            // head slot read was issued on the request beat
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data_ff;
            rd_ptr_in    = ptr_next(rd_ptr_ff);
            occ_in       = occ_ff - 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            // rd_data_ff holds the entry addressed in the previous cycle
            rd_addr      = scan_ptr_ff;
            scan_ptr_in  = ptr_next(scan_ptr_ff);
            scan_left_in = scan_left_ff - 1'b1;
            if (scan_match || (scan_left_ff == OCC_W'(1))) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = scan_match;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= req_value_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      scan_left_ff  <= scan_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      if (accept) begin
         value_ff <= req_value_in;
      end
   end

   assign occ_next_ext = CMP_W'(occ_ff);

   // flags follow the live occupancy, which has settled on the response beat
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = occ_next_ext[COUNT_W-1:0];
   assign rsp_is_empty    = (occ_ff == '0);
   assign rsp_is_full     = is_full_f(occ_ff, cap_ff);

`ifndef SYNTHESIS
   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while a request is still in progress");

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy beyond queue depth");

   a_request_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_left_ff != '0) && (occ_ff != '0))
      else $error("find scan running with nothing left to compare");

   a_deq_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ) |=> (rsp_valid && $past(occ_ff) != '0))
      else $error("dequeue read on an empty queue");
`endif

endmodule
